// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, muted while reset is held
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error(msg);

// Condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error(msg);

`endif

// ----- rtl/mmn_pkg.sv -----
package mmn_pkg;

  // Result field widths
  localparam int SCALED_W = 17;
  localparam int POS_W    = 6;

  // Quotient of (x - min) * 2^16 / (max - min): 17 bits, one per divider step
  localparam int QBITS    = 17;
  localparam int STEP_W   = 5;

  // 1.0 in unsigned Q1.16
  localparam logic [SCALED_W-1:0] ONE_Q16 = 17'h10000;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/mmn_ram.sv -----
module mmn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/mmn_div.sv -----
`include "assert_macros.svh"

module mmn_div #(
  parameter int W = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [W-1:0]                  off,
  input  logic [W-1:0]                  span,
  output mmn_pkg::div_stat_t            stat,
  output logic [mmn_pkg::SCALED_W-1:0]  quotient
);

  logic [W:0]                      rem_r;
  logic [W-1:0]                    span_r;
  logic [mmn_pkg::QBITS-1:0]       q_r;
  logic [mmn_pkg::STEP_W-1:0]      step_r;
  logic                            busy_r;
  logic                            done_r;
  logic                            ge;
  logic [W:0]                      rem_sub;
  logic [W-1:0]                    rem_keep;

  // Restoring step: compare, subtract when it fits, shift in a zero
  always_comb begin
    ge       = (rem_r >= {1'b0, span_r});
    rem_sub  = rem_r - {1'b0, span_r};
    rem_keep = ge ? rem_sub[W-1:0] : rem_r[W-1:0];
  end

  // Control: one quotient bit per cycle, done pulses after the final bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= mmn_pkg::STEP_W'(mmn_pkg::QBITS);
      end else if (busy_r) begin
        step_r <= step_r - mmn_pkg::STEP_W'(1);
        if (step_r == mmn_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: offset never exceeds span, so the first bit is the integer bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, off};
      span_r <= span;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_keep, 1'b0};
      q_r   <= {q_r[mmn_pkg::QBITS-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

  `ASSERT_NEVER(a_start_busy, clk, rst_n, start && busy_r,
                "divider started while a division is running")
  `ASSERT_CLK(a_q_range, clk, rst_n, done_r |-> (q_r <= mmn_pkg::ONE_Q16),
              "quotient above 1.0")
  `ASSERT_CLK(a_done_pulse, clk, rst_n, done_r |=> !done_r,
              "done held for more than one cycle")

endmodule

// ----- rtl/min_max_normalizer_top.sv -----
// Min-max normalizer.
// Input channel in_*: one sample per transaction in in_tdata, in_tlast marks
// the final sample of a set. Samples are written to a store of STORE_DEPTH
// entries at one per cycle while the running minimum and maximum are kept;
// samples beyond the depth are discarded and flagged.
// The transaction carrying in_tlast starts emission: every stored sample is
// read back in arrival order and scaled to (x - min) * 2^16 / (max - min),
// truncated, unsigned Q1.16. in_tready is low during emission.
// Output channel out_*: one result per stored sample, out_tlast on the last.
// Each result takes a store read, a setup state that starts the bit-serial
// divider, its 17 quotient bits (one quotient bit per cycle), a state to
// see it finish and the load of the output register. When all samples
// are equal the divider is skipped and the scaled result is zero.
// A result waits in the output register while out_tready is low; emission
// stalls until it is taken. After the last result is loaded the block takes
// new samples even if that result still waits.
// Reset (rst_n low, synchronous) empties the set and the output register;
// the store contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module min_max_normalizer_top #(
  parameter int STORE_DEPTH = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [SAMPLE_BITS-1:0] sample, zero padding above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // scaled (17), position (6), set_minimum, set_maximum, zero padding above
  output logic [((mmn_pkg::SCALED_W+mmn_pkg::POS_W+2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  output logic                               out_tlast,
  // [0] all_equal, [1] dropped
  output logic [1:0]                         out_tuser
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int TD_W = ((mmn_pkg::SCALED_W + mmn_pkg::POS_W + 2*SB + 7) / 8) * 8;
  localparam int PAD  = TD_W - (mmn_pkg::SCALED_W + mmn_pkg::POS_W + 2*SB);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_START,
    ST_DIVIDE,
    ST_PUT
  } state_t;

  state_t state_r, state_nxt;

  // Load-side set statistics
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic signed [SB-1:0]  min_r, min_nxt;
  logic signed [SB-1:0]  max_r, max_nxt;
  logic                  ovf_r, ovf_nxt;

  // Emission-side copy of the set
  logic [CW-1:0]         n_r, n_nxt;
  logic signed [SB-1:0]  emin_r, emin_nxt;
  logic signed [SB-1:0]  emax_r, emax_nxt;
  logic                  flat_r, flat_nxt;
  logic                  drop_r, drop_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [mmn_pkg::SCALED_W-1:0]  out_scaled_r, out_scaled_nxt;
  logic [mmn_pkg::POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic                          out_last_r, out_last_nxt;
  logic signed [SB-1:0]          out_min_r, out_min_nxt;
  logic signed [SB-1:0]          out_max_r, out_max_nxt;
  logic                          out_eq_r, out_eq_nxt;
  logic                          out_drop_r, out_drop_nxt;

  logic                          in_fire;
  logic                          has_room;
  logic signed [SB-1:0]          x;
  logic                          wr_en;
  logic [SB-1:0]                 rd_data;
  logic                          div_start;
  logic [SB-1:0]                 div_off;
  logic [SB-1:0]                 div_span;
  mmn_pkg::div_stat_t            div_stat;
  logic [mmn_pkg::SCALED_W-1:0]  div_q;
  logic                          slot_free;
  logic                          idx_last;

  assign in_tready = (state_r == ST_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign x         = signed'(in_tdata[SB-1:0]);
  assign has_room  = (cnt_r < CW'(STORE_DEPTH));
  assign wr_en     = in_fire && has_room;
  assign slot_free = !out_valid_r || out_tready;
  assign idx_last  = (CW'(idx_r) == (n_r - CW'(1)));

  // Offset and span wrap into SB unsigned bits, which holds their true value
  assign div_off   = SB'(signed'(rd_data) - emin_r);
  assign div_span  = SB'(emax_r - emin_r);
  assign div_start = (state_r == ST_START) && !flat_r;

  mmn_ram #(
    .WIDTH (SB),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_tdata[SB-1:0]),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  mmn_div #(
    .W (SB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .off      (div_off),
    .span     (div_span),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Next state: load samples, then read, divide (unless the set is flat) and put each stored sample
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    ovf_nxt        = ovf_r;
    n_nxt          = n_r;
    emin_nxt       = emin_r;
    emax_nxt       = emax_r;
    flat_nxt       = flat_r;
    drop_nxt       = drop_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_scaled_nxt = out_scaled_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    out_eq_nxt     = out_eq_r;
    out_drop_nxt   = out_drop_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          // Store the sample and fold it into the running extremes, or flag it when the store is full
          if (has_room) begin
            cnt_nxt = cnt_r + CW'(1);
            if (cnt_r == '0) begin
              min_nxt = x;
              max_nxt = x;
            end else begin
              if (x < min_r) min_nxt = x;
              if (x > max_r) max_nxt = x;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          // Close the set: hand it to emission and empty the load side
          if (in_tlast) begin
            n_nxt     = cnt_nxt;
            emin_nxt  = min_nxt;
            emax_nxt  = max_nxt;
            flat_nxt  = (min_nxt == max_nxt);
            drop_nxt  = ovf_nxt;
            idx_nxt   = '0;
            cnt_nxt   = '0;
            min_nxt   = '0;
            max_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = flat_r ? ST_PUT : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        // Hold until the output register is free, then advance
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_scaled_nxt = flat_r ? '0 : div_q;
          out_pos_nxt    = mmn_pkg::POS_W'(idx_r);
          out_last_nxt   = idx_last;
          out_min_nxt    = emin_r;
          out_max_nxt    = emax_r;
          out_eq_nxt     = flat_r;
          out_drop_nxt   = drop_r;
          if (idx_last) begin
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      ovf_r       <= 1'b0;
      n_r         <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ovf_r       <= ovf_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    emin_r       <= emin_nxt;
    emax_r       <= emax_nxt;
    flat_r       <= flat_nxt;
    drop_r       <= drop_nxt;
    out_scaled_r <= out_scaled_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
    out_eq_r     <= out_eq_nxt;
    out_drop_r   <= out_drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_drop_r, out_eq_r};
  assign out_tdata  = {{PAD{1'b0}}, out_max_r, out_min_r, out_pos_r, out_scaled_r};

  `ASSERT_CLK(a_count_bound, clk, rst_n, cnt_r <= CW'(STORE_DEPTH),
              "stored count beyond store depth")
  `ASSERT_CLK(a_set_closed, clk, rst_n, (in_fire && in_tlast) |=> (cnt_r == '0 && !ovf_r),
              "load side not emptied after final sample")
  `ASSERT_CLK(a_emit_nonempty, clk, rst_n, (state_r == ST_READ) |-> (n_r != '0),
              "emission started on an empty set")
  `ASSERT_CLK(a_div_flat, clk, rst_n, div_start |-> (div_span != '0),
              "division started with zero span")

endmodule

// ----- tb/min_max_normalizer_top_tb.sv -----
`timescale 1ns / 1ps

module min_max_normalizer_top_tb;

  localparam int DEPTH       = 64;
  localparam int SBITS       = 16;
  localparam int IN_W        = ((SBITS + 7) / 8) * 8;
  localparam int OUT_W       = ((mmn_pkg::SCALED_W + mmn_pkg::POS_W + 2 * SBITS + 7) / 8) * 8;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int ITEM_TARGET = 350;
  localparam int MAX_REPORTS = 10;

  // Value content of one random set
  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_FLAT
  } spread_t;

  typedef struct packed {
    logic [mmn_pkg::SCALED_W-1:0] scaled;
    logic [mmn_pkg::POS_W-1:0]    position;
    logic [SBITS-1:0]             set_min;
    logic [SBITS-1:0]             set_max;
    logic                         is_last;
    logic                         all_equal;
    logic                         dropped;
  } norm_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  // [15:0] sample
  logic [IN_W-1:0]  in_tdata;
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready;
  // [16:0] scaled, [22:17] position, [38:23] set_minimum, [54:39] set_maximum
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  // [0] all_equal, [1] dropped
  logic [1:0]       out_tuser;

  // Shadow of the set being loaded
  logic signed [SBITS-1:0] ld_samples [DEPTH];
  int                      ld_count;
  logic signed [SBITS-1:0] ld_min;
  logic signed [SBITS-1:0] ld_max;
  logic                    ld_overflow;

  norm_result_t pending_results [$];
  norm_result_t got_result;
  norm_result_t want_result;

  int mismatches;
  int sent_items;
  int idle_cycles;
  int hold_left;
  int stall_left;
  bit no_idle;

  min_max_normalizer_top #(
    .STORE_DEPTH(DEPTH),
    .SAMPLE_BITS(SBITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Load one sample into the shadow set; on the final sample queue its results
  function automatic void absorb_sample(logic signed [SBITS-1:0] x, logic is_last);
    norm_result_t r;
    longint       span;
    longint       offset;
    longint       quot;
    bit           flat;
    if (ld_count < DEPTH) begin
      if (ld_count == 0) begin
        ld_min = x;
        ld_max = x;
      end else begin
        if (x < ld_min) ld_min = x;
        if (x > ld_max) ld_max = x;
      end
      ld_samples[ld_count] = x;
      ld_count++;
    end else begin
      ld_overflow = 1'b1;
    end
    if (is_last) begin
      flat = (ld_max == ld_min);
      span = longint'(ld_max) - longint'(ld_min);
      for (int k = 0; k < ld_count; k++) begin
        offset      = longint'(ld_samples[k]) - longint'(ld_min);
        quot        = flat ? 0 : (offset << 16) / span;
        r.scaled    = quot[mmn_pkg::SCALED_W-1:0];
        r.position  = k[mmn_pkg::POS_W-1:0];
        r.set_min   = ld_min;
        r.set_max   = ld_max;
        r.is_last   = (k == ld_count - 1);
        r.all_equal = flat;
        r.dropped   = ld_overflow;
        pending_results = {pending_results, r};
      end
      ld_count    = 0;
      ld_min      = '0;
      ld_max      = '0;
      ld_overflow = 1'b0;
    end
  endfunction

  // Predict on every input transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) absorb_sample(in_tdata[SBITS-1:0], in_tlast);
  end

  // Compare every output transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result = '{
        scaled:    out_tdata[16:0],
        position:  out_tdata[22:17],
        set_min:   out_tdata[38:23],
        set_max:   out_tdata[54:39],
        is_last:   out_tlast,
        all_equal: out_tuser[0],
        dropped:   out_tuser[1]
      };
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none pending: scaled=%0d pos=%0d",
                   $realtime, got_result.scaled, got_result.position);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result !== want_result) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch at position %0d", $realtime, want_result.position);
            $display("  expected scaled=%0d pos=%0d min=%0d max=%0d last=%0b eq=%0b drop=%0b",
                     want_result.scaled, want_result.position,
                     $signed(want_result.set_min), $signed(want_result.set_max),
                     want_result.is_last, want_result.all_equal, want_result.dropped);
            $display("  actual   scaled=%0d pos=%0d min=%0d max=%0d last=%0b eq=%0b drop=%0b",
                     got_result.scaled, got_result.position,
                     $signed(got_result.set_min), $signed(got_result.set_max),
                     got_result.is_last, got_result.all_equal, got_result.dropped);
          end
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: long hold when asked, random stalls otherwise
  initial begin
    out_tready <= 1'b0;
    stall_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Offer one sample and hold it until accepted; valid stays high afterwards
  task automatic send_sample(input logic [SBITS-1:0] value, input logic is_last);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(value);
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  // Send a whole set of the given size, final sample marked
  task automatic send_set(input int size, input spread_t spread);
    logic [SBITS-1:0] base;
    logic [SBITS-1:0] value;
    base = SBITS'($urandom);
    for (int i = 0; i < size; i++) begin
      case (spread)
        SPREAD_FULL:   value = SBITS'($urandom);
        SPREAD_NARROW: value = base + SBITS'($urandom_range(0, 15));
        default:       value = base;
      endcase
      send_sample(value, i == size - 1);
    end
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
  endtask

  // Extremes of the sample range and alternating bit patterns
  task automatic test_extremes();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h0001, 1'b1);
    // span of one
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFE, 1'b1);
    wait_drain();
  endtask

  // Flat sets: a single sample and repeated values
  task automatic test_equal_samples();
    send_sample(16'h8000, 1'b1);
    for (int i = 0; i < 5; i++) send_sample(16'hA5A5, i == 4);
    wait_drain();
  endtask

  // Exactly full store, then overflow with out-of-range extremes discarded
  task automatic test_full_store();
    send_set(DEPTH, SPREAD_FULL);
    wait_drain();
    for (int i = 0; i < DEPTH; i++) send_sample(16'h0100 + SBITS'(i % 7), 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    wait_drain();
  endtask

  // Hold the receiver off while the sender keeps offering sets
  task automatic test_backpressure();
    no_idle   = 1'b1;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 3; i++) send_set(6, SPREAD_FULL);
    no_idle = 1'b0;
    wait_drain();
  endtask

  // Random sets, mostly small, a few near or past the store depth
  task automatic test_random_sets();
    int      roll;
    int      size;
    spread_t spread;
    while (sent_items < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 80)      size = $urandom_range(1, 8);
      else if (roll < 95) size = $urandom_range(9, 20);
      else                size = $urandom_range(DEPTH - 4, DEPTH + 4);
      roll = $urandom_range(0, 9);
      if (roll < 6)      spread = SPREAD_FULL;
      else if (roll < 9) spread = SPREAD_NARROW;
      else               spread = SPREAD_FLAT;
      no_idle = ($urandom_range(0, 9) == 0);
      send_set(size, spread);
      if ($urandom_range(0, 7) == 0) wait_drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    idle_cycles <= 0;
    ld_count    = 0;
    ld_min      = '0;
    ld_max      = '0;
    ld_overflow = 1'b0;
    mismatches  = 0;
    sent_items  = 0;
    hold_left   = 0;
    no_idle     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_equal_samples();
    test_full_store();
    test_backpressure();
    test_random_sets();

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
